@@ hdl/sle_pkg.sv @@
// Shared types and constants for the sprite line evaluator.
// Holds the sequencer state type, the result record and register indexes.
// No dependencies.
package sle_pkg;

	localparam int SPR_ENTRIES = 64;
	localparam int IDX_W       = $clog2(SPR_ENTRIES);
	localparam int TBL_DEPTH   = 256;
	localparam int ADDR_W      = $clog2(TBL_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [7:0] TERM_Y   = 8'd208;
	localparam logic [7:0] WRAP_Y   = 8'd240;
	localparam logic [7:0] X_BASE   = 8'h80;
	localparam logic [7:0] P_BASE   = 8'h81;
	localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(8);

	typedef enum logic [2:0] {
		REG_EXT_MODE = 3'd0,
		REG_TALL     = 3'd1,
		REG_ZOOM     = 3'd2,
		REG_LIMIT    = 3'd3,
		REG_ACTIVE_H = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_Y,
		S_X,
		S_P,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic       found;
		logic [5:0] slot;
		logic [4:0] row;
		logic [7:0] x;
		logic [7:0] pat;
		logic       ovr;
		logic       last;
	} result_t;

endpackage

@@ hdl/sprite_line_evaluator_core.sv @@
// Sprite line evaluator: attribute table, scan sequencer and result register.
// Uses sle_pkg for the state type, result record and constants.
// A write item is taken whenever the sequencer is idle. An evaluation holds the input while
// the sequencer reads each Y entry scanned and the X and pattern bytes of each selected sprite
// through the single table read port; output stalls hold it longer. The final result is offered
// as the input frees. Reset clears control state and registers; table undefined until written.
module sprite_line_evaluator_core
	import sle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [7:0]        table_address,
	input  logic [7:0]        table_byte,
	input  logic [8:0]        scanline,
	input  logic [7:0]        line_counter,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              sprite_found,
	output logic [5:0]        slot,
	output logic [4:0]        row_in_sprite,
	output logic [7:0]        x_position,
	output logic [7:0]        pattern,
	output logic              overflow,
	output logic              last
);

	// configuration
	logic [1:0] ext_mode_q;
	logic       tall_q, zoom_q, limit_q;
	logic [7:0] active_h_q;

	// sequencer
	seq_state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovr_q;
	logic [7:0]       vc_q;
	logic [8:0]       line_q;
	logic [4:0]       row_q;
	logic [7:0]       x_q;

	// attribute table
	logic [7:0] tbl_mem [TBL_DEPTH];
	logic [7:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;

	// pending and output results
	result_t pend_q, out_q, new_res, fin_res;
	logic    pend_v_q, out_v_q;

	logic in_acc, out_free, idx_end;
	logic [9:0] row_w;
	logic [5:0] height;
	logic y_term, y_hit, y_over, y_stop, can_push;
	logic ld_row, ld_x, do_push, do_fin, step_idx, set_ovr;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_v_q || !out_stall;
	assign idx_end  = (idx_q == IDX_W'(SPR_ENTRIES - 1));
	assign can_push = !pend_v_q || out_free;

	// Y evaluation: a Y above the wrap point counts as Y minus 256
	assign height = 6'd8 << ({1'b0, tall_q} + {1'b0, zoom_q});
	assign row_w  = {2'b00, vc_q} - {{2{rd_q > WRAP_Y}}, rd_q};
	assign y_term = (ext_mode_q == 2'd0) && (rd_q == TERM_Y);
	assign y_hit  = !row_w[9] && (row_w[8:0] < {3'b000, height});
	assign y_over = y_hit && (cnt_q == LIMIT_CNT);
	assign y_stop = y_term || (y_over && limit_q);

	always_comb begin
		new_res.found = 1'b1;
		new_res.slot  = cnt_q[5:0];
		new_res.row   = row_q;
		new_res.x     = x_q;
		new_res.pat   = rd_q;
		new_res.ovr   = 1'b0;
		new_res.last  = 1'b0;
		if (pend_v_q) begin
			fin_res      = pend_q;
			fin_res.ovr  = ovr_q;
			fin_res.last = 1'b1;
		end else begin
			fin_res      = '0;
			fin_res.last = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && opcode == OP_EVAL)
					state_d = S_Y;
			end
			S_Y: begin
				if (y_stop)
					state_d = S_FIN;
				else if (y_hit)
					state_d = S_X;
				else if (idx_end)
					state_d = S_FIN;
			end
			S_X: state_d = S_P;
			S_P: begin
				if (can_push)
					state_d = idx_end ? S_FIN : S_Y;
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_addr  = '0;
		ld_row   = 1'b0;
		ld_x     = 1'b0;
		do_push  = 1'b0;
		do_fin   = 1'b0;
		step_idx = 1'b0;
		set_ovr  = 1'b0;
		unique case (state_q)
			S_IDLE: rd_addr = '0;
			S_Y: begin
				// the end-of-list marker ends the scan before any overflow count
				set_ovr = !y_term && y_over && (line_q < {1'b0, active_h_q});
				if (!y_stop && y_hit) begin
					ld_row  = 1'b1;
					rd_addr = X_BASE + ADDR_W'({idx_q, 1'b0});
				end else if (!y_stop && !idx_end) begin
					step_idx = 1'b1;
					rd_addr  = ADDR_W'(idx_q) + ADDR_W'(1);
				end
			end
			S_X: begin
				ld_x    = 1'b1;
				rd_addr = P_BASE + ADDR_W'({idx_q, 1'b0});
			end
			S_P: begin
				if (can_push) begin
					do_push = 1'b1;
					if (!idx_end) begin
						step_idx = 1'b1;
						rd_addr  = ADDR_W'(idx_q) + ADDR_W'(1);
					end
				end else begin
					// hold the pattern read until the result can move on
					rd_addr = P_BASE + ADDR_W'({idx_q, 1'b0});
				end
			end
			S_FIN: do_fin = out_free;
			default: rd_addr = '0;
		endcase
	end

	// table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_acc && opcode == OP_WRITE)
			tbl_mem[table_address] <= table_byte;
		rd_q <= tbl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_mode_q <= 2'd0;
			tall_q     <= 1'b0;
			zoom_q     <= 1'b0;
			limit_q    <= 1'b1;
			active_h_q <= 8'd192;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXT_MODE: ext_mode_q <= cfg_data[1:0];
				REG_TALL:     tall_q     <= cfg_data[0];
				REG_ZOOM:     zoom_q     <= cfg_data[0];
				REG_LIMIT:    limit_q    <= cfg_data[0];
				REG_ACTIVE_H: active_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			ovr_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && opcode == OP_EVAL) begin
				idx_q <= '0;
				cnt_q <= '0;
				ovr_q <= 1'b0;
			end
			if (step_idx)
				idx_q <= idx_q + IDX_W'(1);
			if (set_ovr)
				ovr_q <= 1'b1;
			if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
			if (do_push) begin
				cnt_q    <= cnt_q + CNT_W'(1);
				pend_v_q <= 1'b1;
				if (pend_v_q)
					out_v_q <= 1'b1;
			end
			if (do_fin) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && opcode == OP_EVAL) begin
			vc_q   <= line_counter;
			line_q <= scanline;
		end
		if (ld_row)
			row_q <= row_w[4:0];
		if (ld_x)
			x_q <= rd_q;
		if (do_push) begin
			pend_q <= new_res;
			if (pend_v_q)
				out_q <= pend_q;
		end
		if (do_fin)
			out_q <= fin_res;
	end

	assign out_valid     = out_v_q;
	assign sprite_found  = out_q.found;
	assign slot          = out_q.slot;
	assign row_in_sprite = out_q.row;
	assign x_position    = out_q.x;
	assign pattern       = out_q.pat;
	assign overflow      = out_q.ovr;
	assign last          = out_q.last;

endmodule

@@ bench/sprite_line_evaluator_core_tb.sv @@
// Self-checking bench for sprite_line_evaluator_core: table writes, scanline evaluations
// and register phases, with a predictor of the expected sprite list per evaluation.
// Depends on sle_pkg and the core RTL only.
`timescale 1ns / 100ps

module sprite_line_evaluator_core_tb;
	import sle_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 20;

	// Tracks the attribute table and registers, and holds the sprite list still due.
	class sprite_scan_tracker;
		logic [7:0]  tbl [TBL_DEPTH];
		bit          wr [TBL_DEPTH];
		logic [1:0]  ext_mode;
		logic        tall;
		logic        zoom;
		logic        limit_en;
		logic [7:0]  act_h;
		result_t     due_sprites [$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			ext_mode     = 2'd0;
			tall         = 1'b0;
			zoom         = 1'b0;
			limit_en     = 1'b1;
			act_h        = 8'd192;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return due_sprites.size();
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] v);
			case (idx)
				REG_EXT_MODE: ext_mode = v[1:0];
				REG_TALL:     tall     = v[0];
				REG_ZOOM:     zoom     = v[0];
				REG_LIMIT:    limit_en = v[0];
				REG_ACTIVE_H: act_h    = v;
				default: ;
			endcase
		endfunction

		// Address of the first byte a scan of line lc would read before it was written, or -1.
		function int scan_gap(logic [7:0] lc);
			int         height;
			int         count;
			int         yp;
			int         row;
			logic [7:0] xa;
			logic [7:0] pa;
			height = 8;
			if (tall) height = height * 2;
			if (zoom) height = height * 2;
			count = 0;
			for (int i = 0; i < SPR_ENTRIES; i++) begin
				if (!wr[i]) return i;
				yp = int'(tbl[i]);
				if (ext_mode == 2'd0 && tbl[i] == TERM_Y) break;
				if (yp > int'(WRAP_Y)) yp = yp - 256;
				row = int'(lc) - yp;
				if (row < 0 || row >= height) continue;
				if (count == int'(LIMIT_CNT) && limit_en) break;
				xa = X_BASE + 8'(2 * i);
				pa = P_BASE + 8'(2 * i);
				if (!wr[xa]) return int'(xa);
				if (!wr[pa]) return int'(pa);
				count++;
			end
			return -1;
		endfunction

		function void note_item(opcode_t op, logic [7:0] addr, logic [7:0] data,
				logic [8:0] sl, logic [7:0] lc);
			int      height;
			int      count;
			int      yp;
			int      row;
			bit      ovr;
			result_t r;
			if (op == OP_WRITE) begin
				tbl[addr] = data;
				wr[addr]  = 1'b1;
				return;
			end
			height = 8;
			if (tall) height = height * 2;
			if (zoom) height = height * 2;
			count = 0;
			ovr   = 1'b0;
			for (int i = 0; i < SPR_ENTRIES; i++) begin
				yp = int'(tbl[i]);
				// only extension mode 0 knows the end-of-list marker
				if (ext_mode == 2'd0 && tbl[i] == TERM_Y) break;
				if (yp > int'(WRAP_Y)) yp = yp - 256;
				row = int'(lc) - yp;
				if (row < 0 || row >= height) continue;
				if (count == int'(LIMIT_CNT)) begin
					if (sl < {1'b0, act_h}) ovr = 1'b1;
					if (limit_en) break;
				end
				r.found = 1'b1;
				r.slot  = 6'(count);
				r.row   = 5'(row);
				r.x     = tbl[X_BASE + 8'(2 * i)];
				r.pat   = tbl[P_BASE + 8'(2 * i)];
				r.ovr   = 1'b0;
				r.last  = 1'b0;
				due_sprites.push_back(r);
				count++;
			end
			if (count == 0) begin
				r = '0;
				r.last = 1'b1;
				due_sprites.push_back(r);
			end else begin
				due_sprites[$].ovr  = ovr;
				due_sprites[$].last = 1'b1;
			end
		endfunction

		function void cmp_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (due_sprites.size() == 0) begin
				$display("%0t unexpected result: expected none actual found %0d slot %0d last %0d",
					$time, got.found, got.slot, got.last);
				mismatches++;
				return;
			end
			want = due_sprites.pop_front();
			cmp_field("sprite_found", want.found, got.found);
			cmp_field("slot", want.slot, got.slot);
			cmp_field("row_in_sprite", want.row, got.row);
			cmp_field("x_position", want.x, got.x);
			cmp_field("pattern", want.pat, got.pat);
			cmp_field("overflow", want.ovr, got.ovr);
			cmp_field("last", want.last, got.last);
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_we        = 1'b0;
	logic [2:0] cfg_index     = '0;
	logic [7:0] cfg_data      = '0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic       opcode        = 1'b0;
	logic [7:0] table_address = '0;
	logic [7:0] table_byte    = '0;
	logic [8:0] scanline      = '0;
	logic [7:0] line_counter  = '0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic       sprite_found;
	logic [5:0] slot;
	logic [4:0] row_in_sprite;
	logic [7:0] x_position;
	logic [7:0] pattern;
	logic       overflow;
	logic       last;

	sprite_scan_tracker sb;
	int items_sent = 0;
	int tx_quiet   = 0;
	bit hold_req   = 1'b0;

	int ph_ext   [N_PHASES] = '{0, 1, 2, 3, 0, 0};
	int ph_tall  [N_PHASES] = '{0, 1, 1, 0, 1, 0};
	int ph_zoom  [N_PHASES] = '{0, 0, 1, 1, 0, 0};
	int ph_limit [N_PHASES] = '{1, 1, 0, 0, 1, 0};
	int ph_act_h [N_PHASES] = '{192, 224, 255, 0, 100, 192};

	sprite_line_evaluator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.table_address (table_address),
		.table_byte    (table_byte),
		.scanline      (scanline),
		.line_counter  (line_counter),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sprite_found  (sprite_found),
		.slot          (slot),
		.row_in_sprite (row_in_sprite),
		.x_position    (x_position),
		.pattern       (pattern),
		.overflow      (overflow),
		.last          (last)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (tx_quiet > 0) begin
			tx_quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			tx_quiet = $urandom_range(10, 30);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	// Favour lines either side of the active height so the overflow gate is exercised.
	function automatic logic [8:0] pick_scanline();
		int v;
		if ($urandom_range(0, 99) < 55) begin
			v = $urandom_range(0, 312);
		end else begin
			v = int'(sb.act_h) + int'($urandom_range(0, 2)) - 1;
			if (v < 0) v = 0;
		end
		return 9'(v);
	endfunction

	task automatic send_item(opcode_t op, logic [7:0] addr, logic [7:0] data,
			logic [8:0] sl, logic [7:0] lc);
		int gap;
		in_valid      <= 1'b1;
		opcode        <= op;
		table_address <= addr;
		table_byte    <= data;
		scanline      <= sl;
		line_counter  <= lc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(op, addr, data, sl, lc);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_byte(logic [7:0] addr, logic [7:0] data);
		send_item(OP_WRITE, addr, data, 9'($urandom_range(0, 312)), 8'($urandom));
	endtask

	// Write every byte the scan would read before it was written, then send the evaluation.
	task automatic evaluate(logic [8:0] sl, logic [7:0] lc);
		int gap_addr;
		gap_addr = sb.scan_gap(lc);
		while (gap_addr >= 0) begin
			put_byte(8'(gap_addr), 8'($urandom));
			gap_addr = sb.scan_gap(lc);
		end
		send_item(OP_EVAL, 8'($urandom), 8'($urandom), sl, lc);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	// Hold the sender until every due result has arrived and the core has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Cluster Y bytes just above a chosen line so that several sprites land on it.
	task automatic scene_round();
		int base;
		int n;
		int idx;
		int y;
		int r;
		base = $urandom_range(0, 255);
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 8'($urandom));
			evaluate(pick_scanline(), 8'($urandom));
			return;
		end
		n   = $urandom_range(1, 12);
		idx = $urandom_range(0, SPR_ENTRIES - 1);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 3) y = int'(TERM_Y);
			else if (r < 10) y = $urandom_range(241, 255);
			else y = (base - int'($urandom_range(0, 34))) & 255;
			put_byte(8'(idx), 8'(y));
			if ($urandom_range(0, 1)) begin
				put_byte(X_BASE + 8'(2 * idx), 8'($urandom));
				put_byte(P_BASE + 8'(2 * idx), 8'($urandom));
			end
			idx = (idx + $urandom_range(1, 3)) % SPR_ENTRIES;
		end
		repeat ($urandom_range(1, 3)) evaluate(pick_scanline(), 8'(base + $urandom_range(0, 3)));
	endtask

	initial begin : rx
		int     stall_left;
		int     free_left;
		int     r;
		result_t got;
		stall_left = 0;
		free_left  = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {sprite_found, slot, row_in_sprite, x_position, pattern, overflow, last};
				sb.check_result(got);
			end
			// a requested hold-off lets the core back up into its input
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (free_left > 0) begin
				out_stall <= 1'b0;
				free_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
				end else if (r < 80) begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(0, 2);
				end else if (r < 95) begin
					out_stall <= 1'b0;
					free_left = $urandom_range(5, 30);
				end else begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(15, 60);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("sprite_line_evaluator_core regression: fail");
		$finish;
	end

	initial begin : stim
		int target;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seed every Y byte; X and pattern bytes follow just before a scan first reads them
		for (int a = 0; a < SPR_ENTRIES; a++)
			put_byte(8'(a), 8'd200);

		evaluate(9'd0, 8'd0);
		evaluate(9'd100, 8'd200);
		evaluate(9'd192, 8'd207);
		evaluate(9'd312, 8'd255);
		put_byte(8'd3, TERM_Y);
		evaluate(9'd0, 8'd200);
		put_byte(8'd0, 8'd250);
		evaluate(9'd5, 8'd0);
		put_byte(8'd1, 8'd241);
		put_byte(8'd2, WRAP_Y);
		evaluate(9'd191, 8'd247);
		evaluate(9'd300, 8'd1);
		put_byte(8'd3, 8'd200);
		evaluate(9'd191, 8'd200);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				settle();
				put_reg(REG_EXT_MODE, 8'(ph_ext[p]));
				put_reg(REG_TALL, 8'(ph_tall[p]));
				put_reg(REG_ZOOM, 8'(ph_zoom[p]));
				put_reg(REG_LIMIT, 8'(ph_limit[p]));
				put_reg(REG_ACTIVE_H, 8'(ph_act_h[p]));
				cfg_we <= 1'b0;
			end
			if (p == 1) hold_req = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) scene_round();
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d items and %0d results across %0d register settings",
			items_sent, sb.results_seen, N_PHASES);
		$display("mismatches: %0d, results still due: %0d", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("sprite_line_evaluator_core regression: pass");
		end else begin
			$display("sprite_line_evaluator_core regression: fail");
		end
		$finish;
	end

endmodule
